// ===== sv/tbim_pkg.sv =====
// Package for the two-body invariant mass pipeline.
// Holds the transaction payload types, the status codes and the saturation limit.
// No dependencies.
`default_nettype none

package tbim_pkg;

   localparam int unsigned MASS_WIDTH = 31;
   localparam logic [MASS_WIDTH-1:0] MASS_MAX = {MASS_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNKNOWN   = 2'd1,
      STATUS_NEGATIVE  = 2'd2,
      STATUS_SATURATED = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [31:0]      first_px;
      logic signed [31:0]      first_py;
      logic signed [31:0]      first_pz;
      logic [MASS_WIDTH-1:0]   first_mass;
      logic                    first_known;
      logic signed [31:0]      second_px;
      logic signed [31:0]      second_py;
      logic signed [31:0]      second_pz;
      logic [MASS_WIDTH-1:0]   second_mass;
      logic                    second_known;
   } req_type;

   typedef struct packed {
      logic [MASS_WIDTH-1:0]   pair_mass;
      status_type              status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/tbim_if.sv =====
// Valid/ready channel interfaces for the request and response transactions.
// Depends on tbim_pkg for the payload types.
`default_nettype none

interface tbim_req_if import tbim_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tbim_rsp_if import tbim_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/tbim_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Carries a side-band word alongside each radicand. No package dependencies.
`default_nettype none

module tbim_sqrt #(
   parameter int unsigned RAD_WIDTH  = 64,
   parameter int unsigned SIDE_WIDTH = 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        in_valid,
   input  wire logic [RAD_WIDTH-1:0]        in_rad,
   input  wire logic [SIDE_WIDTH-1:0]       in_side,
   output logic                             out_valid,
   output logic [RAD_WIDTH/2-1:0]           out_root,
   output logic [SIDE_WIDTH-1:0]            out_side
);

   localparam int unsigned ROOT_WIDTH = RAD_WIDTH / 2;
   localparam int unsigned REM_WIDTH  = ROOT_WIDTH + 3;
   localparam int unsigned STAGES     = ROOT_WIDTH;

   logic                   v_ff    [STAGES];
   logic [REM_WIDTH-1:0]   rem_ff  [STAGES];
   logic [ROOT_WIDTH-1:0]  root_ff [STAGES];
   logic [RAD_WIDTH-1:0]   rad_ff  [STAGES];
   logic [SIDE_WIDTH-1:0]  side_ff [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic                   p_v;
      logic [REM_WIDTH-1:0]   p_rem;
      logic [ROOT_WIDTH-1:0]  p_root;
      logic [RAD_WIDTH-1:0]   p_rad;
      logic [SIDE_WIDTH-1:0]  p_side;
      logic [REM_WIDTH-1:0]   cur;
      logic [REM_WIDTH-1:0]   trial;
      logic                   take;

      // previous stage, or the input port for the first stage
      if (g == 0) begin : g_first
         assign p_v    = in_valid;
         assign p_rem  = '0;
         assign p_root = '0;
         assign p_rad  = in_rad;
         assign p_side = in_side;
      end else begin : g_next
         assign p_v    = v_ff[g-1];
         assign p_rem  = rem_ff[g-1];
         assign p_root = root_ff[g-1];
         assign p_rad  = rad_ff[g-1];
         assign p_side = side_ff[g-1];
      end

      // bring down two radicand bits, try root bit = 1
      assign cur   = {p_rem[REM_WIDTH-3:0], p_rad[RAD_WIDTH-1 -: 2]};
      assign trial = {1'b0, p_root, 2'b01};
      assign take  = (cur >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (advance) begin
            v_ff[g] <= p_v;
         end
         if (advance) begin
            rem_ff[g]  <= take ? (cur - trial) : cur;
            root_ff[g] <= {p_root[ROOT_WIDTH-2:0], take};
            rad_ff[g]  <= {p_rad[RAD_WIDTH-3:0], 2'b00};
            side_ff[g] <= p_side;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

`default_nettype wire

// ===== sv/two_body_invariant_mass.sv =====
// Two-body invariant mass, Q.16 fixed point, fully pipelined.
// Pipeline: 2 square/sum stages, 32 energy root stages, 3 combine stages,
// 33 mass root stages and 1 output register.
// Throughput: one transaction per cycle; a stalled response freezes the pipe.
// Reset (synchronous, active high) clears all stage valid bits.
`default_nettype none

module two_body_invariant_mass import tbim_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   tbim_req_if.sink         req_link,
   tbim_rsp_if.source       rsp_link
);

   logic adv;

   // stage A: squares and momentum sums
   logic               a_v_ff;
   logic [61:0]        a_m1_ff, a_m2_ff;
   logic [63:0]        a_x1_ff, a_y1_ff, a_z1_ff, a_x2_ff, a_y2_ff, a_z2_ff;
   logic signed [32:0] a_sx_ff, a_sy_ff, a_sz_ff;
   logic               a_known_ff;

   // stage B: energy radicands
   logic               b_v_ff;
   logic [63:0]        b_s1_ff, b_s2_ff;
   logic signed [32:0] b_sx_ff, b_sy_ff, b_sz_ff;
   logic               b_known_ff;

   // energy roots
   logic               e1_v, e2_v;
   logic [31:0]        e1_root, e2_root;
   logic [98:0]        e1_side;
   logic [0:0]         e2_side;
   logic signed [32:0] r_sx, r_sy, r_sz;

   // stage C: energy sum and momentum squares
   logic               c_v_ff;
   logic [32:0]        c_esum_ff;
   logic [65:0]        c_qx_ff, c_qy_ff, c_qz_ff;
   logic               c_known_ff;

   // stage D: (E1+E2)^2 and |p1+p2|^2
   logic               d_v_ff;
   logic [65:0]        d_e2_ff, d_p2_ff;
   logic               d_known_ff;

   // stage E: mass radicand
   logic               e_v_ff;
   logic [65:0]        e_diff_ff;
   logic               e_neg_ff;
   logic               e_known_ff;

   // mass root
   logic               m_v;
   logic [32:0]        m_root;
   logic [1:0]         m_side;

   // output register
   logic               o_v_ff;
   rsp_type            o_rsp_ff;

   assign adv            = !o_v_ff || rsp_link.ready;
   assign req_link.ready = adv;

   // stage A
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_link.valid;
      end
      if (adv) begin
         a_m1_ff    <= req_link.payload.first_mass * req_link.payload.first_mass;
         a_m2_ff    <= req_link.payload.second_mass * req_link.payload.second_mass;
         a_x1_ff    <= req_link.payload.first_px * req_link.payload.first_px;
         a_y1_ff    <= req_link.payload.first_py * req_link.payload.first_py;
         a_z1_ff    <= req_link.payload.first_pz * req_link.payload.first_pz;
         a_x2_ff    <= req_link.payload.second_px * req_link.payload.second_px;
         a_y2_ff    <= req_link.payload.second_py * req_link.payload.second_py;
         a_z2_ff    <= req_link.payload.second_pz * req_link.payload.second_pz;
         a_sx_ff    <= 33'(req_link.payload.first_px) + 33'(req_link.payload.second_px);
         a_sy_ff    <= 33'(req_link.payload.first_py) + 33'(req_link.payload.second_py);
         a_sz_ff    <= 33'(req_link.payload.first_pz) + 33'(req_link.payload.second_pz);
         a_known_ff <= req_link.payload.first_known & req_link.payload.second_known;
      end
   end

   // stage B
   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (adv) begin
         b_v_ff <= a_v_ff;
      end
      if (adv) begin
         b_s1_ff    <= 64'(a_m1_ff) + a_x1_ff + a_y1_ff + a_z1_ff;
         b_s2_ff    <= 64'(a_m2_ff) + a_x2_ff + a_y2_ff + a_z2_ff;
         b_sx_ff    <= a_sx_ff;
         b_sy_ff    <= a_sy_ff;
         b_sz_ff    <= a_sz_ff;
         b_known_ff <= a_known_ff;
      end
   end

   // per-particle energies
   tbim_sqrt #(.RAD_WIDTH(64), .SIDE_WIDTH(99)) u_energy1 (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (b_v_ff),
      .in_rad    (b_s1_ff),
      .in_side   ({b_sx_ff, b_sy_ff, b_sz_ff}),
      .out_valid (e1_v),
      .out_root  (e1_root),
      .out_side  (e1_side)
   );

   tbim_sqrt #(.RAD_WIDTH(64), .SIDE_WIDTH(1)) u_energy2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (b_v_ff),
      .in_rad    (b_s2_ff),
      .in_side   (b_known_ff),
      .out_valid (e2_v),
      .out_root  (e2_root),
      .out_side  (e2_side)
   );

   assign r_sx = e1_side[98:66];
   assign r_sy = e1_side[65:33];
   assign r_sz = e1_side[32:0];

   // stage C
   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (adv) begin
         c_v_ff <= e1_v & e2_v;
      end
      if (adv) begin
         c_esum_ff  <= {1'b0, e1_root} + {1'b0, e2_root};
         c_qx_ff    <= r_sx * r_sx;
         c_qy_ff    <= r_sy * r_sy;
         c_qz_ff    <= r_sz * r_sz;
         c_known_ff <= e2_side[0];
      end
   end

   // stage D
   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (adv) begin
         d_v_ff <= c_v_ff;
      end
      if (adv) begin
         d_e2_ff    <= c_esum_ff * c_esum_ff;
         d_p2_ff    <= c_qx_ff + c_qy_ff + c_qz_ff;
         d_known_ff <= c_known_ff;
      end
   end

   // stage E
   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (adv) begin
         e_v_ff <= d_v_ff;
      end
      if (adv) begin
         e_diff_ff  <= d_e2_ff - d_p2_ff;
         e_neg_ff   <= (d_p2_ff > d_e2_ff);
         e_known_ff <= d_known_ff;
      end
   end

   // pair mass root
   tbim_sqrt #(.RAD_WIDTH(66), .SIDE_WIDTH(2)) u_mass (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (e_v_ff),
      .in_rad    (e_diff_ff),
      .in_side   ({e_known_ff, e_neg_ff}),
      .out_valid (m_v),
      .out_root  (m_root),
      .out_side  (m_side)
   );

   // output register: status priority unknown, negative, saturated
   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (adv) begin
         o_v_ff <= m_v;
      end
      if (adv) begin
         if (!m_side[1]) begin
            o_rsp_ff.pair_mass <= '0;
            o_rsp_ff.status    <= STATUS_UNKNOWN;
         end else if (m_side[0]) begin
            o_rsp_ff.pair_mass <= '0;
            o_rsp_ff.status    <= STATUS_NEGATIVE;
         end else if (m_root[32] || m_root[31]) begin
            o_rsp_ff.pair_mass <= MASS_MAX;
            o_rsp_ff.status    <= STATUS_SATURATED;
         end else begin
            o_rsp_ff.pair_mass <= m_root[30:0];
            o_rsp_ff.status    <= STATUS_OK;
         end
      end
   end

   assign rsp_link.valid   = o_v_ff;
   assign rsp_link.payload = o_rsp_ff;

endmodule

`default_nettype wire

// ===== tb/tbim_mass_checker.sv =====
// Checker for the two-body invariant mass pipeline: watches both channels,
// predicts each response from the request and compares field by field.
// Depends on tbim_pkg and the channel interfaces in tbim_if.sv.
`default_nettype none

module tbim_mass_checker import tbim_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   tbim_req_if.sink    req_mon,
   tbim_rsp_if.sink    rsp_mon,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   rsp_type expected_masses[$];

   // floor(sqrt(v)) for v below 2^68, bit by bit
   function automatic logic [33:0] floor_root(input logic [67:0] v);
      logic [33:0] r;
      logic [33:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         c = r | (34'd1 << b);
         if ({34'd0, c} * {34'd0, c} <= v) r = c;
      end
      return r;
   endfunction

   // Q.16 energy of one particle from Q.32 sum of squares
   function automatic logic [33:0] particle_energy(input logic signed [31:0] px,
      input logic signed [31:0] py, input logic signed [31:0] pz,
      input logic [MASS_WIDTH-1:0] m);
      logic signed [67:0] x, y, z;
      logic [67:0] s;
      x = px; y = py; z = pz;
      s = {37'd0, m} * {37'd0, m};
      s = s + x * x + y * y + z * z;
      return floor_root(s);
   endfunction

   function automatic rsp_type predict_mass(input req_type q);
      rsp_type r;
      logic [67:0] esum, e2, p2, diff;
      logic signed [67:0] sx, sy, sz;
      logic [33:0] root;
      r.pair_mass = '0;
      if (!q.first_known || !q.second_known) begin
         r.status = STATUS_UNKNOWN;
         return r;
      end
      esum = particle_energy(q.first_px, q.first_py, q.first_pz, q.first_mass)
           + particle_energy(q.second_px, q.second_py, q.second_pz, q.second_mass);
      e2 = esum * esum;
      sx = 68'(q.first_px) + 68'(q.second_px);
      sy = 68'(q.first_py) + 68'(q.second_py);
      sz = 68'(q.first_pz) + 68'(q.second_pz);
      p2 = sx * sx + sy * sy + sz * sz;
      if (p2 > e2) begin
         r.status = STATUS_NEGATIVE;
         return r;
      end
      diff = e2 - p2;
      root = floor_root(diff);
      if (root > 34'(MASS_MAX)) begin
         r.pair_mass = MASS_MAX;
         r.status = STATUS_SATURATED;
      end else begin
         r.pair_mass = root[MASS_WIDTH-1:0];
         r.status = STATUS_OK;
      end
      return r;
   endfunction

   assign pending_count = expected_masses.size();

   // predict on request, compare on response
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_masses.delete();
         fail_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_masses.push_back(predict_mass(req_mon.payload));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_masses.size() == 0) begin
               if (fail_count < 10) $display("response with nothing expected: mass %0d status %0d",
                  rsp_mon.payload.pair_mass, rsp_mon.payload.status);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_masses.pop_front();
               if (want.pair_mass !== rsp_mon.payload.pair_mass ||
                   want.status !== rsp_mon.payload.status) begin
                  if (fail_count < 10)
                     $display("mismatch: expected mass %0d status %0d, got mass %0d status %0d",
                        want.pair_mass, want.status, rsp_mon.payload.pair_mass,
                        rsp_mon.payload.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

`default_nettype wire

// ===== tb/two_body_invariant_mass_tb.sv =====
// Top of the two-body invariant mass testbench: clock, reset, request
// stimulus with bursts and gaps, response stalls, watchdog and verdict.
// Depends on tbim_pkg, tbim_if.sv, tbim_mass_checker and the block.
`default_nettype none

module two_body_invariant_mass_tb import tbim_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 71;
   localparam int IDLE_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int fail_count, pending_count;
   int idle_cycles = 0;
   bit stall_enable = 1'b1;

   tbim_req_if req_link ();
   tbim_rsp_if rsp_link ();

   two_body_invariant_mass uut (.clock(clock), .reset(reset),
      .req_link(req_link.sink), .rsp_link(rsp_link.source));

   tbim_mass_checker checker_inst (.clock(clock), .reset(reset),
      .req_mon(req_link.sink), .rsp_mon(rsp_link.sink),
      .fail_count(fail_count), .pending_count(pending_count));

   always #5 clock = ~clock;

   initial begin
      req_link.valid = 1'b0;
      req_link.payload = '0;
      rsp_link.ready = 1'b0;
   end

   // receiver stall pattern: phases of always-ready and random stalls
   always @(posedge clock) begin
      int phase;
      phase = ($urandom_range(0, 511) < 8) ? $urandom_range(0, 2) : -1;
      if (!stall_enable) rsp_link.ready <= 1'b1;
      else rsp_link.ready <= ($urandom_range(0, 3) != 0) || (phase == 0);
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_link.valid && req_link.ready) || (rsp_link.valid && rsp_link.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("two_body_invariant_mass verification failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_momentum(input int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         2: return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $signed($urandom) >>> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic req_type random_pair();
      req_type q;
      int mode;
      mode = $urandom_range(0, 3);
      q.first_px = rand_momentum(mode);
      q.first_py = rand_momentum(mode);
      q.first_pz = rand_momentum(mode);
      q.second_px = rand_momentum($urandom_range(0, 3));
      q.second_py = rand_momentum(mode);
      q.second_pz = rand_momentum(mode);
      q.first_mass = ($urandom_range(0, 4) == 0) ? '0 : MASS_WIDTH'($urandom >> $urandom_range(1, 31));
      q.second_mass = ($urandom_range(0, 4) == 0) ? '0 : MASS_WIDTH'($urandom >> $urandom_range(1, 31));
      q.first_known = ($urandom_range(0, 9) != 0);
      q.second_known = ($urandom_range(0, 9) != 0);
      // massless collinear pairs probe the negative radicand
      if ($urandom_range(0, 7) == 0) begin
         q.first_mass = '0;
         q.second_mass = '0;
         q.second_px = q.first_px;
         q.second_py = q.first_py;
         q.second_pz = q.first_pz;
      end
      return q;
   endfunction

   task automatic send_pair(input req_type q);
      req_link.valid <= 1'b1;
      req_link.payload <= q;
      do @(posedge clock); while (!req_link.ready);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         req_link.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain_wait();
      idle_gap(1);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      req_type q;
      int burst;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, unknown types, zero, saturation, collinear pairs
      for (int k = 0; k < 20; k++) begin
         q = '0;
         q.first_known = 1'b1;
         q.second_known = 1'b1;
         case (k)
            0: ;
            1: q.first_known = 1'b0;
            2: q.second_known = 1'b0;
            3: begin q.first_known = 1'b0; q.second_known = 1'b0; end
            4: begin q.first_mass = MASS_MAX; q.second_mass = MASS_MAX; end
            5: begin
               q.first_px = 32'sh7FFF_FFFF; q.first_py = 32'sh7FFF_FFFF;
               q.first_pz = 32'sh7FFF_FFFF; q.second_px = 32'sh8000_0000;
               q.second_py = 32'sh8000_0000; q.second_pz = 32'sh8000_0000;
               q.first_mass = MASS_MAX; q.second_mass = MASS_MAX;
            end
            6: begin
               q.first_px = 32'sh8000_0000; q.first_py = 32'sh8000_0000;
               q.first_pz = 32'sh8000_0000; q.second_px = 32'sh8000_0000;
               q.second_py = 32'sh8000_0000; q.second_pz = 32'sh8000_0000;
            end
            7: begin q.first_px = 32'sh0001_0000; q.second_px = 32'sh0001_0000; end
            8: begin q.first_px = 32'sh0000_0003; q.first_py = 32'sh0000_0005;
               q.second_px = 32'sh0000_0003; q.second_py = 32'sh0000_0005; end
            9: begin q.first_px = 32'sh0001_0000; q.second_px = -32'sh0001_0000; end
            10: begin q.first_mass = 31'h0001_0000; q.second_mass = 31'h0002_0000; end
            11: begin q.first_px = 32'sh7FFF_FFFF; q.second_px = 32'sh7FFF_FFFF; end
            default: q = random_pair();
         endcase
         send_pair(q);
      end
      drain_wait();

      // random bursts with gaps; one full drain midway
      for (int n = 0; n < 1200; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && n < 1200; b++, n++) send_pair(random_pair());
         if (n >= 600 && n < 600 + burst) drain_wait();
         else if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
         if (n > 900) stall_enable = 1'b0;
         else if (n > 300) stall_enable = 1'b1;
      end
      idle_gap(1);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("two_body_invariant_mass verification clean");
      else
         $display("two_body_invariant_mass verification failed");
      $finish;
   end
endmodule

`default_nettype wire
